>>> rtl/core/pba_pkg.sv
// Shared types, codes and constants for the proximity beep alarm.
`timescale 1ns / 1ps

package pba_pkg;

    localparam int TIME_W   = 32;
    localparam int DIST_W   = 17;
    localparam int GAP_W    = 16;
    localparam int BAND_W   = 2;
    localparam int PHASE_W  = 2;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 17;

    localparam int S_TDATA_W = 56;   // 32 + 17 = 49 bits, padded to 7 bytes
    localparam int M_TDATA_W = 8;    // 1 + 1 + 2 = 4 bits, padded to 1 byte

    localparam logic [GAP_W-1:0] BEEP_ON_MS = 16'd100;

    // band codes
    localparam logic [BAND_W-1:0] BAND_NONE = 2'd0;
    localparam logic [BAND_W-1:0] BAND_FAR  = 2'd1;
    localparam logic [BAND_W-1:0] BAND_MID  = 2'd2;
    localparam logic [BAND_W-1:0] BAND_NEAR = 2'd3;

    // beep sequencer phases
    localparam logic [PHASE_W-1:0] PH_IDLE = 2'd0;
    localparam logic [PHASE_W-1:0] PH_ON   = 2'd1;
    localparam logic [PHASE_W-1:0] PH_OFF  = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MID_LIMIT  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NEAR_GAP   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MID_GAP    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FAR_GAP    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_DWELL      = 3'd6;

    // configuration reset values
    localparam logic [DIST_W-1:0] NEAR_LIMIT_RST = 17'd200;
    localparam logic [DIST_W-1:0] MID_LIMIT_RST  = 17'd400;
    localparam logic [DIST_W-1:0] FAR_LIMIT_RST  = 17'd600;
    localparam logic [GAP_W-1:0]  NEAR_GAP_RST   = 16'd250;
    localparam logic [GAP_W-1:0]  MID_GAP_RST    = 16'd500;
    localparam logic [GAP_W-1:0]  FAR_GAP_RST    = 16'd1000;
    localparam logic [GAP_W-1:0]  DWELL_RST      = 16'd5000;

    typedef struct packed {
        logic [DIST_W-1:0] near_limit;
        logic [DIST_W-1:0] mid_limit;
        logic [DIST_W-1:0] far_limit;
        logic [GAP_W-1:0]  near_gap_ms;
        logic [GAP_W-1:0]  mid_gap_ms;
        logic [GAP_W-1:0]  far_gap_ms;
    } band_cfg_t;

    typedef struct packed {
        logic [BAND_W-1:0] band;
        logic [GAP_W-1:0]  gap_ms;
    } band_info_t;

endpackage

>>> rtl/core/pba_band.sv
// Distance band classifier: picks the band and its beep gap.
`timescale 1ns / 1ps

module pba_band (
    input  logic [pba_pkg::DIST_W-1:0] distance_x10,
    input  pba_pkg::band_cfg_t         cfg,
    output pba_pkg::band_info_t        info
);

    always_comb begin
        priority if (distance_x10 < cfg.near_limit) begin
            info.band   = pba_pkg::BAND_NEAR;
            info.gap_ms = cfg.near_gap_ms;
        end else if (distance_x10 < cfg.mid_limit) begin
            info.band   = pba_pkg::BAND_MID;
            info.gap_ms = cfg.mid_gap_ms;
        end else if (distance_x10 < cfg.far_limit) begin
            info.band   = pba_pkg::BAND_FAR;
            info.gap_ms = cfg.far_gap_ms;
        end else begin
            info.band   = pba_pkg::BAND_NONE;
            info.gap_ms = '0;
        end
    end

endmodule

>>> rtl/core/pba_dwell.sv
// Near-band dwell timer with one-shot retreat pulse.
`timescale 1ns / 1ps

module pba_dwell (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [pba_pkg::TIME_W-1:0]  time_ms,
    input  logic [pba_pkg::BAND_W-1:0]  band,
    input  logic [pba_pkg::GAP_W-1:0]   danger_dwell_ms,
    output logic                        retreat_pulse
);

    logic                       active_reg, active_next;
    logic                       done_reg, done_next;
    logic [pba_pkg::TIME_W-1:0] start_reg, start_next;
    logic [pba_pkg::TIME_W-1:0] elapsed;

    always_comb begin
        active_next   = active_reg;
        done_next     = done_reg;
        start_next    = start_reg;
        retreat_pulse = 1'b0;
        elapsed       = '0;
        if (band == pba_pkg::BAND_NEAR) begin
            if (!active_reg) begin
                active_next = 1'b1;
                start_next  = time_ms;
                done_next   = 1'b0;
            end
            // modulo 2^32 elapsed time
            elapsed = time_ms - start_next;
            if (!done_next && (elapsed >= {16'd0, danger_dwell_ms})) begin
                done_next     = 1'b1;
                retreat_pulse = 1'b1;
            end
        end else begin
            active_next = 1'b0;
            done_next   = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            start_reg  <= '0;
        end else if (step) begin
            active_reg <= active_next;
            done_reg   <= done_next;
            start_reg  <= start_next;
        end
    end

endmodule

>>> rtl/core/pba_beep.sv
// Beep sequencer: idle, on and off phases driving the tone enable.
`timescale 1ns / 1ps

module pba_beep (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        step,
    input  logic [pba_pkg::TIME_W-1:0]  time_ms,
    input  pba_pkg::band_info_t         info,
    output logic                        tone_enable
);

    logic                          tone_reg, tone_next;
    logic                          loop_reg, loop_next;
    logic [pba_pkg::PHASE_W-1:0]   phase_reg, phase_next;
    logic [pba_pkg::TIME_W-1:0]    event_reg, event_next;

    always_comb begin
        tone_next  = tone_reg;
        loop_next  = loop_reg;
        phase_next = phase_reg;
        event_next = event_reg;
        if (info.band == pba_pkg::BAND_NONE) begin
            if (loop_reg) begin
                tone_next  = 1'b0;
                phase_next = pba_pkg::PH_IDLE;
                loop_next  = 1'b0;
            end
        end else if (!loop_reg) begin
            // arm only; first beep starts on the following word
            loop_next  = 1'b1;
            phase_next = pba_pkg::PH_IDLE;
            event_next = time_ms;
        end else if (time_ms >= event_reg) begin
            if (phase_reg == pba_pkg::PH_ON) begin
                tone_next  = 1'b0;
                phase_next = pba_pkg::PH_OFF;
                event_next = time_ms + {16'd0, info.gap_ms};
            end else begin
                // idle, off and the unused code all start a beep
                tone_next  = 1'b1;
                phase_next = pba_pkg::PH_ON;
                event_next = time_ms + {16'd0, pba_pkg::BEEP_ON_MS};
            end
        end
    end

    assign tone_enable = tone_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tone_reg  <= 1'b0;
            loop_reg  <= 1'b0;
            phase_reg <= pba_pkg::PH_IDLE;
            event_reg <= '0;
        end else if (step) begin
            tone_reg  <= tone_next;
            loop_reg  <= loop_next;
            phase_reg <= phase_next;
            event_reg <= event_next;
        end
    end

endmodule

>>> rtl/core/proximity_beep_alarm_top.sv
// Top level of the proximity beep alarm: config registers, input and result registers.
`timescale 1ns / 1ps

// One measurement word per clock in, one result word per clock out. The word
// lands in an input register, then the band compare, dwell subtract/compare
// and event-time add/compare run in a single pass into the result register,
// where the sequencer and dwell state also update. While a result waits on
// m_tready the input register can still take one word, then s_tready stays
// low until the result drains. Full throughput holds whenever the sink keeps
// up. Configuration writes take effect on the next word processed.
module proximity_beep_alarm_top (
    input  logic                               aclk,
    input  logic                               aresetn,
    // configuration
    input  logic                               cfg_we,
    input  logic [pba_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pba_pkg::CFG_DATA_W-1:0]     cfg_data,
    // measurement stream
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [pba_pkg::S_TDATA_W-1:0]      s_tdata,  // [31:0] time_ms, [48:32] distance_x10
    // result stream
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [pba_pkg::M_TDATA_W-1:0]      m_tdata   // [0] tone_enable, [1] retreat_pulse,
                                                         // [3:2] band
);

    pba_pkg::band_cfg_t              band_cfg_reg;
    logic [pba_pkg::GAP_W-1:0]       dwell_reg;

    logic                            in_valid_reg;
    logic [pba_pkg::TIME_W-1:0]      time_reg;
    logic [pba_pkg::DIST_W-1:0]      dist_reg;

    logic                            out_valid_reg;
    logic                            tone_reg;
    logic                            pulse_reg;
    logic [pba_pkg::BAND_W-1:0]      band_reg;

    logic                            step;
    pba_pkg::band_info_t             info;
    logic                            tone_enable;
    logic                            retreat_pulse;

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            band_cfg_reg.near_limit  <= pba_pkg::NEAR_LIMIT_RST;
            band_cfg_reg.mid_limit   <= pba_pkg::MID_LIMIT_RST;
            band_cfg_reg.far_limit   <= pba_pkg::FAR_LIMIT_RST;
            band_cfg_reg.near_gap_ms <= pba_pkg::NEAR_GAP_RST;
            band_cfg_reg.mid_gap_ms  <= pba_pkg::MID_GAP_RST;
            band_cfg_reg.far_gap_ms  <= pba_pkg::FAR_GAP_RST;
            dwell_reg                <= pba_pkg::DWELL_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                pba_pkg::REG_NEAR_LIMIT: band_cfg_reg.near_limit  <= cfg_data;
                pba_pkg::REG_MID_LIMIT:  band_cfg_reg.mid_limit   <= cfg_data;
                pba_pkg::REG_FAR_LIMIT:  band_cfg_reg.far_limit   <= cfg_data;
                pba_pkg::REG_NEAR_GAP:   band_cfg_reg.near_gap_ms <= cfg_data[pba_pkg::GAP_W-1:0];
                pba_pkg::REG_MID_GAP:    band_cfg_reg.mid_gap_ms  <= cfg_data[pba_pkg::GAP_W-1:0];
                pba_pkg::REG_FAR_GAP:    band_cfg_reg.far_gap_ms  <= cfg_data[pba_pkg::GAP_W-1:0];
                pba_pkg::REG_DWELL:      dwell_reg                <= cfg_data[pba_pkg::GAP_W-1:0];
                default: ;
            endcase
        end
    end

    // a held word moves on when the result register is free or being drained
    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            time_reg <= s_tdata[pba_pkg::TIME_W-1:0];
            dist_reg <= s_tdata[pba_pkg::TIME_W+pba_pkg::DIST_W-1:pba_pkg::TIME_W];
        end
    end

    pba_band u_band (
        .distance_x10 (dist_reg),
        .cfg          (band_cfg_reg),
        .info         (info)
    );

    pba_dwell u_dwell (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .step            (step),
        .time_ms         (time_reg),
        .band            (info.band),
        .danger_dwell_ms (dwell_reg),
        .retreat_pulse   (retreat_pulse)
    );

    pba_beep u_beep (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step        (step),
        .time_ms     (time_reg),
        .info        (info),
        .tone_enable (tone_enable)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step) begin
            tone_reg  <= tone_enable;
            pulse_reg <= retreat_pulse;
            band_reg  <= info.band;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, band_reg, pulse_reg, tone_reg};

endmodule

>>> rtl/core/pba_checker.sv
// Port-level assertions for the proximity beep alarm, bound to the top level.
`timescale 1ns / 1ps

module pba_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [pba_pkg::M_TDATA_W-1:0]  m_tdata
);

    // nothing comes out of reset as a pending result word
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // retreat only fires inside the near band
    a_pulse_near: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[1] |-> m_tdata[3:2] == pba_pkg::BAND_NEAR)
        else $error("retreat pulse outside near band");

    // tone is silent whenever the target is out of range
    a_tone_band: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[3:2] != pba_pkg::BAND_NONE)
        else $error("tone on with no band");

endmodule

bind proximity_beep_alarm_top pba_checker u_pba_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
